/* hw/rtl/qmr_pkg.sv */
// ----------------------------------------------------------------------------
// qmr_pkg
// Widths, component indexes and saturation helpers shared by the quaternion
// product / rotation pipeline.
// ----------------------------------------------------------------------------
package qmr_pkg;

  localparam int Q_W       = 16;  // Q1.14 component
  localparam int FRAC_BITS = 14;
  localparam int P1_W      = 32;  // a*b product
  localparam int S1_W      = 34;  // sum of four a*b products
  localparam int T_W       = S1_W - FRAC_BITS;  // rounded first product
  localparam int TW_W      = 18;  // wrapped rotation intermediate
  localparam int C_W       = 17;  // conjugate component, holds +32768
  localparam int P2_W      = TW_W + C_W;
  localparam int S2_W      = 36;  // sum of four t*conj products
  localparam int R_W       = S2_W - FRAC_BITS;  // rounded second product
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  localparam int QX = 0;
  localparam int QY = 1;
  localparam int QZ = 2;
  localparam int QW = 3;

  localparam logic signed [R_W-1:0] SAT_MAX = R_W'(32767);
  localparam logic signed [R_W-1:0] SAT_MIN = -R_W'(32768);

  typedef logic [3:0][Q_W-1:0] quat_t;
  typedef logic [3:0][T_W-1:0] tq_t;

  function automatic logic clip16(input logic signed [R_W-1:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

  function automatic logic [Q_W-1:0] sat16(input logic signed [R_W-1:0] v);
    logic [Q_W-1:0] res;
    if (v > SAT_MAX) begin
      res = SAT_MAX[Q_W-1:0];
    end else if (v < SAT_MIN) begin
      res = SAT_MIN[Q_W-1:0];
    end else begin
      res = v[Q_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/qmr_first.sv */
// ----------------------------------------------------------------------------
// qmr_first
// First Hamilton product a*b (b scalar zeroed for a rotation): one stage of
// sixteen products, one stage of sums with round to nearest.
// ----------------------------------------------------------------------------
module qmr_first
  import qmr_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  logic  kind,
  input  quat_t a,
  input  quat_t b,
  output logic  kind_q,
  output quat_t a_q,
  output tq_t   t
);

  quat_t                   bq;
  logic                    kind_p;
  quat_t                   a_p;
  logic signed [P1_W-1:0]  m  [4][4];
  logic signed [S1_W-1:0]  s  [4];
  logic signed [S1_W-1:0]  sr [4];

  always_comb begin
    bq = b;
    if (kind) begin
      bq[QW] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_p <= kind;
      a_p    <= a;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          m[i][j] <= $signed(a[i]) * $signed(bq[j]);
        end
      end
    end
  end

  always_comb begin
    s[QX] =  m[QW][QX] - m[QZ][QY] + m[QY][QZ] + m[QX][QW];
    s[QY] =  m[QZ][QX] + m[QW][QY] - m[QX][QZ] + m[QY][QW];
    s[QZ] = -m[QY][QX] + m[QX][QY] + m[QW][QZ] + m[QZ][QW];
    s[QW] = -m[QX][QX] - m[QY][QY] - m[QZ][QZ] + m[QW][QW];
    for (int k = 0; k < 4; k++) begin
      sr[k] = s[k] + S1_W'(HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_q <= kind_p;
      a_q    <= a_p;
      for (int k = 0; k < 4; k++) begin
        t[k] <= sr[k][S1_W-1:FRAC_BITS];
      end
    end
  end

endmodule

/* hw/rtl/qmr_second.sv */
// ----------------------------------------------------------------------------
// qmr_second
// Second Hamilton product t*conj(a) for rotations, then saturation of the
// final components. Products pass straight to saturation otherwise.
// ----------------------------------------------------------------------------
module qmr_second
  import qmr_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  logic  kind,
  input  quat_t a,
  input  tq_t   t,
  output quat_t r,
  output logic  saturated
);

  logic signed [TW_W-1:0] ts [4];
  logic signed [C_W-1:0]  c  [4];
  logic                   kind_p;
  tq_t                    t_p;
  logic signed [P2_W-1:0] mm [4][4];
  logic signed [S2_W-1:0] s  [4];
  logic signed [S2_W-1:0] sr [4];
  logic signed [R_W-1:0]  v  [4];
  quat_t                  r_next;
  logic                   saturated_next;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ts[k] = $signed(t[k][TW_W-1:0]);
    end
    c[QX] = -$signed({a[QX][Q_W-1], a[QX]});
    c[QY] = -$signed({a[QY][Q_W-1], a[QY]});
    c[QZ] = -$signed({a[QZ][Q_W-1], a[QZ]});
    c[QW] =  $signed({a[QW][Q_W-1], a[QW]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_p <= kind;
      t_p    <= t;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          mm[i][j] <= ts[i] * c[j];
        end
      end
    end
  end

  always_comb begin
    s[QX] =  mm[QW][QX] - mm[QZ][QY] + mm[QY][QZ] + mm[QX][QW];
    s[QY] =  mm[QZ][QX] + mm[QW][QY] - mm[QX][QZ] + mm[QY][QW];
    s[QZ] = -mm[QY][QX] + mm[QX][QY] + mm[QW][QZ] + mm[QZ][QW];
    s[QW] = -mm[QX][QX] - mm[QY][QY] - mm[QZ][QZ] + mm[QW][QW];
    for (int k = 0; k < 4; k++) begin
      sr[k] = s[k] + S2_W'(HALF);
      if (kind_p) begin
        v[k] = $signed(sr[k][S2_W-1:FRAC_BITS]);
      end else begin
        v[k] = $signed({{(R_W-T_W){t_p[k][T_W-1]}}, t_p[k]});
      end
      r_next[k] = sat16(v[k]);
    end
    saturated_next = clip16(v[QX]) || clip16(v[QY]) || clip16(v[QZ]);
    if (kind_p) begin
      r_next[QW] = '0;
    end else begin
      saturated_next = saturated_next || clip16(v[QW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r         <= r_next;
      saturated <= saturated_next;
    end
  end

endmodule

/* hw/rtl/quaternion_multiply_rotate.sv */
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate
// Q1.14 quaternion Hamilton product (kind 0) or rotation of vector b by
// quaternion a (kind 1), with round to nearest and saturated results.
//
// Input channel: item_valid / item_stall carry kind, a_*, b_*. An item is
// taken at an edge with item_valid high and item_stall low.
// Output channel: result_valid / result_stall carry r_*, saturated, one
// result per item, in order.
// Four register stages: products a*b, sums and rounding, products with
// conj(a), sums, rounding and saturation into the output register. One
// item can enter every cycle while result_stall does not freeze the
// pipeline, since nothing carries over between items and every stage
// takes a new item each cycle.
// When result_stall holds a valid result, the whole pipeline freezes and
// item_stall goes high in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate
  import qmr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 kind,
  input  logic signed [15:0]   a_x,
  input  logic signed [15:0]   a_y,
  input  logic signed [15:0]   a_z,
  input  logic signed [15:0]   a_w,
  input  logic signed [15:0]   b_x,
  input  logic signed [15:0]   b_y,
  input  logic signed [15:0]   b_z,
  input  logic signed [15:0]   b_w,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [15:0]   r_x,
  output logic signed [15:0]   r_y,
  output logic signed [15:0]   r_z,
  output logic signed [15:0]   r_w,
  output logic                 saturated
);

  logic  en;
  logic  v1;
  logic  v2;
  logic  v3;
  quat_t a;
  quat_t b;
  logic  kind_q;
  quat_t a_q;
  tq_t   t;
  quat_t r;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  assign a = {a_w, a_z, a_y, a_x};
  assign b = {b_w, b_z, b_y, b_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= item_valid;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

  qmr_first u_first (
    .clk    (clk),
    .en     (en),
    .kind   (kind),
    .a      (a),
    .b      (b),
    .kind_q (kind_q),
    .a_q    (a_q),
    .t      (t)
  );

  qmr_second u_second (
    .clk       (clk),
    .en        (en),
    .kind      (kind_q),
    .a         (a_q),
    .t         (t),
    .r         (r),
    .saturated (saturated)
  );

  assign r_x = r[QX];
  assign r_y = r[QY];
  assign r_z = r[QZ];
  assign r_w = r[QW];

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v3 && en) |=> result_valid)
    else $error("item lost in last stage");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && saturated) |->
      (r_x == 16'sh7fff || r_x == 16'sh8000 || r_y == 16'sh7fff || r_y == 16'sh8000 ||
       r_z == 16'sh7fff || r_z == 16'sh8000 || r_w == 16'sh7fff || r_w == 16'sh8000))
    else $error("saturated flag without a clipped component");

endmodule
